[hw/rtl/unique_id_membership_set_defines.svh]
// Assertion macros for the membership set block.
`ifndef UNIQUE_ID_MEMBERSHIP_SET_DEFINES_SVH
`define UNIQUE_ID_MEMBERSHIP_SET_DEFINES_SVH
`ifndef SYNTHESIS
`define UIMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define UIMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define UIMS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UIMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/uims_pkg.sv]
// Types and constants of the membership set block.
`default_nettype none
package uims_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ID_WIDTH_DEF = 32;
    localparam int OBJ_ID_W     = 32;
    localparam int COUNT_W      = 7;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t               mode;
        logic [OBJ_ID_W-1:0] object_id;
    } cmd_t;

    typedef struct packed {
        logic               found;
        logic               rejected_full;
        logic [COUNT_W-1:0] member_count;
        logic               is_empty;
    } rsp_t;

endpackage
`default_nettype wire

[hw/rtl/unique_id_membership_set.sv]
// Top level of the ordered membership set with linear search.
//
//  channel | dir | handshake            | payload
//  cmd     | in  | cmd_valid/cmd_stall  | uims_pkg::cmd_t (mode, object_id)
//  rsp     | out | rsp_valid/rsp_stall  | uims_pkg::rsp_t (found, rejected_full, ...)
//
// An absent item is searched over all n held entries; a hit at position pos ends the search.
// A remove that hits closes the gap by shifting the later entries down; clear skips the search.
// The single read port of the entry memory sets the pace: one entry per cycle.
// Reset clears the count, control and output registers; the entry memory is not cleared.
// A stalled result holds in the output register while the next transfer is accepted;
// the finish step waits while that result is still stalled.
`default_nettype none
`include "unique_id_membership_set_defines.svh"
module unique_id_membership_set #(
    parameter int CAPACITY = uims_pkg::CAPACITY_DEF,
    parameter int ID_WIDTH = uims_pkg::ID_WIDTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire uims_pkg::cmd_t cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output uims_pkg::rsp_t      rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FIN
    } state_t;

    state_t                state_reg, state_next;
    uims_pkg::mode_t       mode_reg, mode_next;
    logic [ID_WIDTH-1:0]   key_reg, key_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [CW-1:0]         chk_idx_reg, chk_idx_next;
    logic                  found_reg, found_next;
    logic                  reject_reg, reject_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    uims_pkg::rsp_t        rsp_reg, rsp_next;

    logic [ID_WIDTH-1:0]   mem [CAPACITY];
    logic [ID_WIDTH-1:0]   rd_data_reg;
    logic                  rd_en;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ID_WIDTH-1:0]   wr_data;
    logic [CW-1:0]         prev_idx;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign prev_idx  = CW'(chk_idx_reg - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        found_next     = found_reg;
        reject_next    = reject_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = key_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    mode_next      = cmd.mode;
                    key_next       = ID_WIDTH'(cmd.object_id);
                    found_next     = 1'b0;
                    reject_next    = 1'b0;
                    idx_next       = '0;
                    chk_valid_next = 1'b0;
                    if (cmd.mode == uims_pkg::MODE_CLEAR)
                    begin
                        count_next = '0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (chk_valid_reg && rd_data_reg == key_reg)
                begin
                    found_next     = 1'b1;
                    chk_valid_next = 1'b0;
                    if (mode_reg == uims_pkg::MODE_REMOVE)
                    begin
                        idx_next   = CW'(chk_idx_reg + 1'b1);
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
                else if (idx_reg != count_reg)
                begin
                    rd_en          = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg;
                    idx_next       = CW'(idx_reg + 1'b1);
                end
                else if (chk_valid_reg)
                begin
                    chk_valid_next = 1'b0;
                end
                else
                begin
                    if (mode_reg == uims_pkg::MODE_ADD)
                    begin
                        if (count_reg != CAP_C)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = key_reg;
                            count_next = CW'(count_reg + 1'b1);
                        end
                        else
                        begin
                            reject_next = 1'b1;
                        end
                    end
                    state_next = ST_FIN;
                end
            end
            ST_SHIFT:
            begin
                if (chk_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = prev_idx[AW-1:0];
                    wr_data = rd_data_reg;
                end
                if (idx_reg != count_reg)
                begin
                    rd_en          = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg;
                    idx_next       = CW'(idx_reg + 1'b1);
                end
                else if (chk_valid_reg)
                begin
                    chk_valid_next = 1'b0;
                end
                else
                begin
                    count_next = CW'(count_reg - 1'b1);
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.found         = found_reg;
                    rsp_next.rejected_full = reject_reg;
                    rsp_next.member_count  = uims_pkg::COUNT_W'(count_reg);
                    rsp_next.is_empty      = (count_reg == '0);
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        chk_idx_reg <= chk_idx_next;
        found_reg   <= found_next;
        reject_reg  <= reject_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    `UIMS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CAP_C)
    `UIMS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && !cmd_stall, cmd_stall)
    `UIMS_ASSERT_IMP(a_reject_full, clk, rst_n, rsp_valid && rsp.rejected_full, !rsp.found && !rsp.is_empty)
    `UIMS_ASSERT_IMP(a_scan_write_add, clk, rst_n, wr_en && state_reg == ST_SCAN, mode_reg == uims_pkg::MODE_ADD && !found_reg)

endmodule
`default_nettype wire
